// File: hw/rtl/bca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bitmap chunk allocator.
// No dependencies.
package bca_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] CSR_CHUNK_SIZE   = 2'd0;
   localparam logic [1:0] CSR_BASE_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_POOL_BYTES   = 2'd2;

   localparam int DIV_STEPS = 33;
   localparam int DIV_CNT_W = 6;

   // Field widths of the command word, sized for the largest map.
   localparam int CMD_N_W = 7;
   localparam int CMD_T_W = 17;
   localparam int CMD_W_W = 10;
   localparam int CMD_S_W = 6;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_RUN      = 2'd1,
      ST_MISALIGNED  = 2'd2,
      ST_OUT_OF_POOL = 2'd3
   } status_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] request_size;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] granted_address;
   } rsp_type;

   typedef struct packed {
      logic [31:0] chunk_size;   // already forced nonzero
      logic [31:0] base_address;
      logic [31:0] pool_bytes;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_DONE  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      status_type           status;
      logic [31:0]          granted;
      logic [CMD_N_W-1:0]   n;       // run length (clipped for free)
      logic [CMD_T_W-1:0]   total;   // chunks in pool
      logic [CMD_W_W-1:0]   word;
      logic [CMD_S_W-1:0]   start;
   } cmd_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_DIV_N,
      FR_DIV_TOT,
      FR_DIV_ALG,
      FR_DIV_IDX,
      FR_DIV_WRD,
      FR_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_RD,
      BK_CHK,
      BK_FRD,
      BK_FWR,
      BK_MUL,
      BK_ADD,
      BK_OUT
   } back_state_type;

endpackage

// File: hw/rtl/bitmap_chunk_allocator.sv
`timescale 1ns / 1ps
// Bitmap chunk allocator, top level. Uses bca_pkg, bca_front, bca_back, bca_fifo.
// Flow: an allocate takes two divides (request size and pool size in chunks), then
// the back scans map words until a run fits or all are seen; a full free takes four
// divides and a step to split the index. One word in flight in the front: it takes
// no new request until its current command word has been pushed to the back.
// Reset: synchronous; config returns to 4096/0/4194304, then the map is cleared
// word by word, during which req_full stays high.
module bitmap_chunk_allocator #(
   parameter int WORD_BITS = 64,
   parameter int MAP_WORDS = 16
) (
   input  logic              clock,
   input  logic              reset,
   // request queue side
   input  logic              req_push,
   output logic              req_full,
   input  bca_pkg::req_type  req_data,
   // result queue side
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bca_pkg::rsp_type  rsp_data,
   // register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import bca_pkg::*;

   logic [31:0] chunk_ff, base_ff, pool_ff;
   cfg_type     cfg;
   logic        front_full, clearing;
   logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type     cmd_in, cmd_out;
   logic        rsp_push, rsp_full_int;
   rsp_type     rsp_in;

   // registers always accept; writes must only come while idle (not enforced here)
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= 32'd4096;
         base_ff  <= 32'd0;
         pool_ff  <= 32'd4194304;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CHUNK_SIZE:   chunk_ff <= csr_data;
            CSR_BASE_ADDRESS: base_ff  <= csr_data;
            CSR_POOL_BYTES:   pool_ff  <= csr_data;
            default: ;  // unmapped index: dropped
         endcase
      end
   end

   // zero chunk size behaves as one byte
   assign cfg.chunk_size   = (chunk_ff == '0) ? 32'd1 : chunk_ff;
   assign cfg.base_address = base_ff;
   assign cfg.pool_bytes   = pool_ff;

   // no requests while the map sweep after reset runs
   assign req_full = front_full || clearing;

   bca_front #(.WORD_BITS(WORD_BITS), .MAP_WORDS(MAP_WORDS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push && !req_full),
      .req_full (front_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (cmd_in)
   );

   // decouples front and back
   bca_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(2)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .full  (cmd_full),
      .din   (cmd_in),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .dout  (cmd_out)
   );

   bca_back #(.WORD_BITS(WORD_BITS), .MAP_WORDS(MAP_WORDS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .clearing  (clearing),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_out),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full_int),
      .rsp_data  (rsp_in)
   );

   // result words wait here for the consumer
   bca_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full_int),
      .din   (rsp_in),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .dout  (rsp_data)
   );

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_full)
      else $error("request accepted during map clear");

   a_cmd_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command pushed into full queue");

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full_int)
      else $error("result pushed into full queue");

   a_clear_no_cmd: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !cmd_pop)
      else $error("command taken during map clear");
endmodule

// File: hw/rtl/bca_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bca_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// File: hw/rtl/bca_fifo.sv
`timescale 1ns / 1ps
// Small register FIFO used between front and back and on the result side.
// No dependencies.
module bca_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] dout
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [CW-1:0]    cnt_ff;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign dout    = mem_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wp_ff <= (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
         if (do_pop) begin
            rp_ff <= (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wp_ff] <= din;
      end
   end
endmodule

// File: hw/rtl/bca_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 33-bit by 32-bit.
// Depends on bca_pkg.
module bca_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [32:0] quotient,
   output logic [31:0] remainder
);
   import bca_pkg::*;

   logic [32:0]          rem_ff, quo_ff;
   logic [31:0]          dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [32:0]          trial, diff;
   logic                 ge;

   assign trial     = {rem_ff[31:0], quo_ff[32]};
   assign ge        = (trial >= {1'b0, dvs_ff});
   assign diff      = trial - {1'b0, dvs_ff};
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff : trial;
            quo_ff <= {quo_ff[31:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

// File: hw/rtl/bca_front.sv
`timescale 1ns / 1ps
// Front end: takes a request, works out chunk counts and indexes with the
// shared divider and emits one command word. Depends on bca_pkg, bca_div.
module bca_front #(
   parameter int WORD_BITS = 64,
   parameter int MAP_WORDS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  bca_pkg::cfg_type  cfg,
   input  logic              req_push,
   output logic              req_full,
   input  bca_pkg::req_type  req_data,
   output logic              cmd_push,
   input  logic              cmd_full,
   output bca_pkg::cmd_type  cmd_data
);
   import bca_pkg::*;

   localparam int CAP = MAP_WORDS * WORD_BITS;
   localparam int TW  = $clog2(CAP + 1);
   localparam int SW  = $clog2(WORD_BITS);
   localparam int NW  = $clog2(WORD_BITS + 1);
   // chunk index -> map word by reciprocal multiply, exact for index < 2^TW
   localparam int KSH = TW + SW;
   localparam int RW  = TW + 2;
   localparam logic [RW-1:0] RECIP =
      RW'(((64'd1 << KSH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

   front_state_type state_ff, state_in;
   logic            issued_ff;
   req_type         req_ff;
   logic [32:0]     n_ff, word_ff;
   logic [TW-1:0]   idx_ff;
   logic [TW-1:0]   tot_ff;
   logic [SW-1:0]   s_ff;
   logic            mis_ff, oor_ff;

   logic            div_start, div_done;
   logic [32:0]     div_dividend, div_quo;
   logic [31:0]     div_divisor, div_rem;
   logic            is_div;
   logic [NW-1:0]   room;
   logic [32:0]     len;
   logic [TW+RW-1:0] wrd_prod;
   logic [TW-1:0]   wrd_quo, wrd_rem;

   bca_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE:    if (req_push) state_in = FR_DIV_N;
         FR_DIV_N:   if (div_done) state_in = FR_DIV_TOT;
         FR_DIV_TOT: if (div_done) begin
            state_in = (req_ff.operation == OP_ALLOC) ? FR_PUSH : FR_DIV_ALG;
         end
         FR_DIV_ALG: if (div_done) begin
            if (div_rem != '0 || req_ff.address < cfg.base_address) begin
               state_in = FR_PUSH;
            end else begin
               state_in = FR_DIV_IDX;
            end
         end
         FR_DIV_IDX: if (div_done) begin
            state_in = (div_quo >= 33'(tot_ff)) ? FR_PUSH : FR_DIV_WRD;
         end
         FR_DIV_WRD: state_in = FR_PUSH;
         FR_PUSH:    if (!cmd_full) state_in = FR_IDLE;
         default:    state_in = FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      is_div = (state_ff == FR_DIV_N) || (state_ff == FR_DIV_TOT) ||
               (state_ff == FR_DIV_ALG) || (state_ff == FR_DIV_IDX);
      div_start   = is_div && !issued_ff;
      div_divisor = cfg.chunk_size;
      unique case (state_ff)
         FR_DIV_N:   div_dividend = {1'b0, req_ff.request_size} +
                                    {1'b0, cfg.chunk_size} - 33'd1;
         FR_DIV_TOT: div_dividend = {1'b0, cfg.pool_bytes};
         FR_DIV_ALG: div_dividend = {1'b0, req_ff.address};
         FR_DIV_IDX: div_dividend = {1'b0, req_ff.address - cfg.base_address};
         default:    div_dividend = '0;
      endcase
      req_full = (state_ff != FR_IDLE);
      cmd_push = (state_ff == FR_PUSH) && !cmd_full;

      // split the chunk index into map word and bit position
      wrd_prod = (TW+RW)'(idx_ff) * (TW+RW)'(RECIP);
      wrd_quo  = TW'(wrd_prod >> KSH);
      wrd_rem  = idx_ff - wrd_quo * TW'(WORD_BITS);

      room = NW'(WORD_BITS) - NW'(s_ff);
      len  = (n_ff > 33'(room)) ? 33'(room) : n_ff;

      cmd_data         = '0;
      cmd_data.kind    = CMD_DONE;
      cmd_data.status  = ST_OK;
      cmd_data.total   = CMD_T_W'(tot_ff);
      if (req_ff.operation == OP_ALLOC) begin
         priority if (n_ff == '0) begin
            cmd_data.granted = cfg.base_address;
         end else if (n_ff > 33'(WORD_BITS)) begin
            cmd_data.status = ST_NO_RUN;
         end else begin
            cmd_data.kind = CMD_ALLOC;
            cmd_data.n    = CMD_N_W'(n_ff);
         end
      end else begin
         priority if (mis_ff) begin
            cmd_data.status = ST_MISALIGNED;
         end else if (req_ff.address < cfg.base_address || oor_ff) begin
            cmd_data.status = ST_OUT_OF_POOL;
         end else if (n_ff != '0) begin
            cmd_data.kind  = CMD_FREE;
            cmd_data.n     = CMD_N_W'(len);
            cmd_data.word  = CMD_W_W'(word_ff);
            cmd_data.start = CMD_S_W'(s_ff);
         end else begin
            cmd_data.status = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FR_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (div_start) begin
            issued_ff <= 1'b1;
         end else if (div_done) begin
            issued_ff <= 1'b0;
         end
      end
      if (state_ff == FR_IDLE && req_push) begin
         req_ff <= req_data;
         mis_ff <= 1'b0;
         oor_ff <= 1'b0;
      end
      if (state_ff == FR_DIV_WRD) begin
         word_ff <= 33'(wrd_quo);
         s_ff    <= wrd_rem[SW-1:0];
      end
      if (div_done) begin
         unique case (state_ff)
            FR_DIV_N:   n_ff <= div_quo;
            FR_DIV_TOT: tot_ff <= (div_quo > 33'(CAP)) ? TW'(CAP) : div_quo[TW-1:0];
            FR_DIV_ALG: mis_ff <= (div_rem != '0);
            FR_DIV_IDX: begin
               idx_ff <= div_quo[TW-1:0];
               oor_ff <= (div_quo >= 33'(tot_ff));
            end
            default: ;
         endcase
      end
   end
endmodule

// File: hw/rtl/bca_back.sv
`timescale 1ns / 1ps
// Back end: owns the used-bit map, walks it for allocations, clears runs
// for frees and forms the result word. Depends on bca_pkg, bca_ram.
module bca_back #(
   parameter int WORD_BITS = 64,
   parameter int MAP_WORDS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  bca_pkg::cfg_type  cfg,
   output logic              clearing,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  bca_pkg::cmd_type  cmd_data,
   output logic              rsp_push,
   input  logic              rsp_full,
   output bca_pkg::rsp_type  rsp_data
);
   import bca_pkg::*;

   localparam int CAP = MAP_WORDS * WORD_BITS;
   localparam int TW  = $clog2(CAP + 1);
   localparam int SW  = $clog2(WORD_BITS);
   localparam int NW  = $clog2(WORD_BITS + 1);
   localparam int WW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff;
   logic [WW-1:0]        wcnt_ff;
   logic [TW-1:0]        start_ff, idx_ff;
   logic [31:0]          prod_ff;
   rsp_type              rsp_ff;

   logic                 ram_we;
   logic [WW-1:0]        ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

   logic [NW-1:0]        n;
   logic [SW-1:0]        s;
   logic [WORD_BITS-1:0] run, busy, fit_mask, free_mask;
   logic [SW-1:0]        fit_s;
   logic                 found, last_word;

   bca_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // first-fit search over one map word
   always_comb begin
      n = cmd_ff.n[NW-1:0];
      s = cmd_ff.start[SW-1:0];
      for (int b = 0; b < WORD_BITS; b++) begin
         run[b]       = (NW'(b) < n);
         busy[b]      = ram_rdata[b] || ((start_ff + TW'(b)) >= cmd_ff.total[TW-1:0]);
         free_mask[b] = (SW'(b) >= s) && ((NW'(b) - NW'(s)) < n);
      end
      found = 1'b0;
      fit_s = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (({1'b0, NW'(i)} + {1'b0, n} <= {1'b0, NW'(WORD_BITS)}) &&
             ((busy & (run << i)) == '0)) begin
            found = 1'b1;
            fit_s = SW'(i);
         end
      end
      fit_mask  = run << fit_s;
      last_word = (wcnt_ff == WW'(MAP_WORDS - 1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: if (wcnt_ff == WW'(MAP_WORDS - 1)) state_in = BK_IDLE;
         BK_IDLE:  if (!cmd_empty) begin
            unique case (cmd_data.kind)
               CMD_ALLOC: state_in = BK_RD;
               CMD_FREE:  state_in = BK_FRD;
               default:   state_in = BK_OUT;
            endcase
         end
         BK_RD:    state_in = BK_CHK;
         BK_CHK:   begin
            priority if (found)     state_in = BK_MUL;
            else if (last_word)     state_in = BK_OUT;
            else                    state_in = BK_RD;
         end
         BK_FRD:   state_in = BK_FWR;
         BK_FWR:   state_in = BK_OUT;
         BK_MUL:   state_in = BK_ADD;
         BK_ADD:   state_in = BK_OUT;
         BK_OUT:   if (!rsp_full) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      clearing  = (state_ff == BK_CLEAR);
      cmd_pop   = (state_ff == BK_IDLE) && !cmd_empty;
      rsp_push  = (state_ff == BK_OUT) && !rsp_full;
      rsp_data  = rsp_ff;
      ram_we    = 1'b0;
      ram_waddr = wcnt_ff;
      ram_wdata = '0;
      ram_raddr = wcnt_ff;
      unique case (state_ff)
         BK_CLEAR: ram_we = 1'b1;
         BK_CHK:   begin
            ram_we    = found;
            ram_wdata = ram_rdata | fit_mask;
         end
         BK_FRD:   ram_raddr = cmd_ff.word[WW-1:0];
         BK_FWR:   begin
            ram_we    = 1'b1;
            ram_waddr = cmd_ff.word[WW-1:0];
            ram_wdata = ram_rdata & ~free_mask;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         wcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            BK_CLEAR: wcnt_ff <= (wcnt_ff == WW'(MAP_WORDS - 1)) ? '0 : wcnt_ff + 1'b1;
            BK_IDLE:  wcnt_ff <= '0;
            BK_CHK:   if (!found && !last_word) wcnt_ff <= wcnt_ff + 1'b1;
            default: ;
         endcase
      end
      unique case (state_ff)
         BK_IDLE: begin
            cmd_ff   <= cmd_data;
            start_ff <= '0;
            rsp_ff   <= '{status: cmd_data.status, granted_address: cmd_data.granted};
         end
         BK_CHK: begin
            idx_ff   <= start_ff + TW'(fit_s);
            start_ff <= start_ff + TW'(WORD_BITS);
            rsp_ff   <= '{status: ST_NO_RUN, granted_address: 32'd0};
         end
         BK_FWR: rsp_ff <= '{status: ST_OK, granted_address: 32'd0};
         BK_MUL: prod_ff <= 32'(idx_ff) * cfg.chunk_size;
         BK_ADD: rsp_ff <= '{status: ST_OK, granted_address: cfg.base_address + prod_ff};
         default: ;
      endcase
   end
endmodule
